>>> sv/assert_macros.svh
// Assertion macros shared by the ray/box intersection RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define RBSI_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RBSI_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RBSI_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RBSI_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> sv/rbsi_pkg.sv
// Shared types and constants for the ray/box slab intersection block.
// No dependencies.
package rbsi_pkg;
    localparam int AXES = 3;

    // Pipeline advance control handed to the datapath submodules.
    typedef struct packed {
        logic en;
    } t_adv;
endpackage

>>> sv/rbsi_ifs.sv
// Request and result channel interfaces for the ray/box intersection block.
// No dependencies.
interface rbsi_ray_if #(parameter int W = 32) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] origin_x;
    logic signed [W-1:0] origin_y;
    logic signed [W-1:0] origin_z;
    logic signed [W-1:0] dir_x;
    logic signed [W-1:0] dir_y;
    logic signed [W-1:0] dir_z;
    logic signed [W-1:0] box_min_x;
    logic signed [W-1:0] box_min_y;
    logic signed [W-1:0] box_min_z;
    logic signed [W-1:0] box_max_x;
    logic signed [W-1:0] box_max_y;
    logic signed [W-1:0] box_max_z;

    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
                    input ready);
    modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
                  output ready);
endinterface

interface rbsi_res_if #(parameter int W = 32) ();
    logic                valid;
    logic                ready;
    logic                hit;
    logic        [W-2:0] entry_dist;
    logic signed [W-1:0] hit_x;
    logic signed [W-1:0] hit_y;
    logic signed [W-1:0] hit_z;

    modport source (output valid, hit, entry_dist, hit_x, hit_y, hit_z, input ready);
    modport sink (input valid, hit, entry_dist, hit_x, hit_y, hit_z, output ready);
endinterface

>>> sv/rbsi_div.sv
// Pipelined restoring divider: floor(num * 2^F / den), saturated to W-1 bits.
// One quotient bit per stage after the first. Depends on rbsi_pkg.
module rbsi_div #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic               i_clk,
    input  rbsi_pkg::t_adv     i_adv,
    input  logic [W:0]         i_num,
    input  logic [W-1:0]       i_den,
    output logic [W-2:0]       o_quo
);
    localparam int NW  = W + 1 + F;
    localparam int CW  = 2 * W + F;
    localparam int NST = W;

    logic [NW-1:0] r_rem [NST];
    logic [W-1:0]  r_den [NST];
    logic [W-2:0]  r_quo [NST];
    logic          r_ovf [NST];

    // The first stage loads the operands and flags quotients that do not fit in W-1 bits.
    always_ff @(posedge i_clk) begin
        if (i_adv.en) begin
            r_rem[0] <= NW'(i_num) << F;
            r_den[0] <= i_den;
            r_quo[0] <= '0;
            r_ovf[0] <= (CW'(i_num) << F) >= (CW'(i_den) << (W - 1));
        end
    end

    for (genvar k = 1; k < NST; k++) begin : g_st
        logic [CW-1:0] w_sub;
        logic          w_ge;

        assign w_sub = CW'(r_den[k-1]) << (W - 1 - k);
        assign w_ge  = CW'(r_rem[k-1]) >= w_sub;

        always_ff @(posedge i_clk) begin
            if (i_adv.en) begin
                r_rem[k] <= w_ge ? NW'(CW'(r_rem[k-1]) - w_sub) : r_rem[k-1];
                r_quo[k] <= r_quo[k-1] | (w_ge ? ((W-1)'(1) << (W - 1 - k)) : '0);
                r_den[k] <= r_den[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign o_quo = r_ovf[NST-1] ? '1 : r_quo[NST-1];
endmodule

>>> sv/rbsi_hitpt.sv
// Hit point for one axis: origin + dir * dist, truncated and saturated.
// Two register stages (multiply, then add and clamp). Depends on rbsi_pkg.
module rbsi_hitpt #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                i_clk,
    input  rbsi_pkg::t_adv      i_adv,
    input  logic [W-1:0]        i_origin,
    input  logic [W-1:0]        i_dmag,
    input  logic                i_dneg,
    input  logic [W-2:0]        i_dist,
    output logic signed [W-1:0] o_coord
);
    localparam logic signed [2*W:0] SMAX = $signed({{(W+2){1'b0}}, {(W-1){1'b1}}});
    localparam logic signed [2*W:0] SMIN = $signed({{(W+2){1'b1}}, {(W-1){1'b0}}});

    logic        [2*W-2:0] r_prod;
    logic                  r_neg;
    logic signed [W-1:0]   r_org;
    logic signed [W-1:0]   r_coord;
    logic        [2*W-2:0] w_off;
    logic signed [2*W:0]   w_offs;
    logic signed [2*W:0]   w_sum;

    always_ff @(posedge i_clk) begin
        if (i_adv.en) begin
            r_prod <= (2*W-1)'(i_dmag) * (2*W-1)'(i_dist);
            r_neg  <= i_dneg;
            r_org  <= $signed(i_origin);
        end
    end

    // The magnitude is truncated before the sign is applied.
    assign w_off  = r_prod >> F;
    assign w_offs = $signed({2'b00, w_off});
    assign w_sum  = (r_neg ? -w_offs : w_offs) + (2*W+1)'(r_org);

    always_ff @(posedge i_clk) begin
        if (i_adv.en) begin
            if (w_sum > SMAX) begin
                r_coord <= W'(SMAX);
            end else if (w_sum < SMIN) begin
                r_coord <= W'(SMIN);
            end else begin
                r_coord <= W'(w_sum);
            end
        end
    end

    assign o_coord = r_coord;
endmodule

>>> sv/ray_box_slab_intersect_top.sv
// Ray / axis-aligned box intersection by the slab method in signed fixed point
// (COORD_BITS wide, FRAC_BITS fraction bits). One ray/box request is accepted every
// cycle while the output skid register is empty. A result passes COORD_BITS + 5
// register stages, most of them in the six pipelined slab dividers, which produce
// one quotient bit per stage after their first. A miss (no slab overlap, negative
// entry distance, an origin outside a slab whose direction is zero, or all
// directions zero) returns hit low with all other fields zero. An output skid
// register holds a result that is not taken; while it is full the pipeline and
// the request side stall until it drains, so no request is lost or repeated.
// Depends on rbsi_pkg, rbsi_ifs, rbsi_div, rbsi_hitpt and assert_macros.svh.
`include "assert_macros.svh"
module ray_box_slab_intersect_top #(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rbsi_ray_if.sink    i_ray,
    rbsi_res_if.source  o_res
);
    localparam int W   = COORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int NA  = rbsi_pkg::AXES;
    localparam int DL  = W;
    localparam logic signed [W-1:0] TMIN = $signed({1'b1, {(W-1){1'b0}}});
    localparam logic signed [W-1:0] TMAX = $signed({1'b0, {(W-1){1'b1}}});

    typedef struct packed {
        logic [W-1:0] org;
        logic         dneg;
        logic [W-1:0] dmag;
        logic         dz;
        logic         zm;
        logic         ng0;
        logic         ng1;
    } t_axis_sb;

    rbsi_pkg::t_adv w_adv;
    logic           r_k_v;

    assign w_adv.en    = !r_k_v;
    assign i_ray.ready = !r_k_v;

    // ---------------- Stage 1: slab numerators and zero-direction checks
    logic signed [W-1:0] w_o    [NA];
    logic signed [W-1:0] w_d    [NA];
    logic signed [W-1:0] w_bmin [NA];
    logic signed [W-1:0] w_bmax [NA];

    assign w_o[0] = i_ray.origin_x;  assign w_o[1] = i_ray.origin_y;
    assign w_o[2] = i_ray.origin_z;
    assign w_d[0] = i_ray.dir_x;     assign w_d[1] = i_ray.dir_y;
    assign w_d[2] = i_ray.dir_z;
    assign w_bmin[0] = i_ray.box_min_x;  assign w_bmin[1] = i_ray.box_min_y;
    assign w_bmin[2] = i_ray.box_min_z;
    assign w_bmax[0] = i_ray.box_max_x;  assign w_bmax[1] = i_ray.box_max_y;
    assign w_bmax[2] = i_ray.box_max_z;

    logic         r_s1_v;
    logic [W:0]   r_s1_un0 [NA];
    logic [W:0]   r_s1_un1 [NA];
    t_axis_sb     r_s1_sb  [NA];
    logic [W-2:0] w_q0 [NA];
    logic [W-2:0] w_q1 [NA];

    for (genvar a = 0; a < NA; a++) begin : g_ax
        logic signed [W:0] w_n0;
        logic signed [W:0] w_n1;

        assign w_n0 = (W+1)'(w_bmin[a]) - (W+1)'(w_o[a]);
        assign w_n1 = (W+1)'(w_bmax[a]) - (W+1)'(w_o[a]);

        always_ff @(posedge i_clk) begin
            if (w_adv.en) begin
                r_s1_un0[a]     <= w_n0[W] ? (W+1)'(-w_n0) : (W+1)'(w_n0);
                r_s1_un1[a]     <= w_n1[W] ? (W+1)'(-w_n1) : (W+1)'(w_n1);
                r_s1_sb[a].org  <= w_o[a];
                r_s1_sb[a].dneg <= w_d[a][W-1];
                r_s1_sb[a].dmag <= w_d[a][W-1] ? W'(-w_d[a]) : W'(w_d[a]);
                r_s1_sb[a].dz   <= w_d[a] == '0;
                r_s1_sb[a].zm   <= (w_d[a] == '0) &&
                                   (w_o[a] < w_bmin[a] || w_o[a] > w_bmax[a]);
                r_s1_sb[a].ng0  <= w_n0[W] ^ w_d[a][W-1];
                r_s1_sb[a].ng1  <= w_n1[W] ^ w_d[a][W-1];
            end
        end

        rbsi_div #(.W(W), .F(F)) u_div0 (
            .i_clk (i_clk),
            .i_adv (w_adv),
            .i_num (r_s1_un0[a]),
            .i_den (r_s1_sb[a].dmag),
            .o_quo (w_q0[a])
        );

        rbsi_div #(.W(W), .F(F)) u_div1 (
            .i_clk (i_clk),
            .i_adv (w_adv),
            .i_num (r_s1_un1[a]),
            .i_den (r_s1_sb[a].dmag),
            .o_quo (w_q1[a])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_adv.en) begin
            r_s1_v <= i_ray.valid;
        end
    end

    // ---------------- Side data delayed alongside the dividers
    logic     r_sb_v [DL];
    t_axis_sb r_sb   [DL][NA];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DL; k++) begin
                r_sb_v[k] <= 1'b0;
            end
        end else if (w_adv.en) begin
            r_sb_v[0] <= r_s1_v;
            for (int k = 1; k < DL; k++) begin
                r_sb_v[k] <= r_sb_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv.en) begin
            r_sb[0] <= r_s1_sb;
            for (int k = 1; k < DL; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    // ---------------- Stage A: signed slab distances, put in order
    logic                r_a_v;
    logic signed [W-1:0] r_a_lo [NA];
    logic signed [W-1:0] r_a_hi [NA];
    t_axis_sb            r_a_sb [NA];

    for (genvar a = 0; a < NA; a++) begin : g_ord
        logic signed [W-1:0] w_t0;
        logic signed [W-1:0] w_t1;

        assign w_t0 = r_sb[DL-1][a].ng0 ? -$signed({1'b0, w_q0[a]}) : $signed({1'b0, w_q0[a]});
        assign w_t1 = r_sb[DL-1][a].ng1 ? -$signed({1'b0, w_q1[a]}) : $signed({1'b0, w_q1[a]});

        always_ff @(posedge i_clk) begin
            if (w_adv.en) begin
                r_a_lo[a] <= (w_t0 > w_t1) ? w_t1 : w_t0;
                r_a_hi[a] <= (w_t0 > w_t1) ? w_t0 : w_t1;
                r_a_sb[a] <= r_sb[DL-1][a];
            end
        end
    end

    // ---------------- Stage B: narrow the interval and decide hit or miss
    logic signed [W-1:0] w_lo;
    logic signed [W-1:0] w_hi;
    logic                w_zm;
    logic                w_alldz;
    logic                w_miss;

    always_comb begin
        w_lo    = TMIN;
        w_hi    = TMAX;
        w_zm    = 1'b0;
        w_alldz = 1'b1;
        for (int a = 0; a < NA; a++) begin
            if (r_a_sb[a].dz) begin
                w_zm = w_zm | r_a_sb[a].zm;
            end else begin
                w_alldz = 1'b0;
                if (r_a_lo[a] > w_lo) begin
                    w_lo = r_a_lo[a];
                end
                if (r_a_hi[a] < w_hi) begin
                    w_hi = r_a_hi[a];
                end
            end
        end
        // With every direction component zero the entry distance is unbounded below.
        w_miss = w_zm || w_alldz || (w_lo > w_hi) || w_lo[W-1];
    end

    logic         r_b_v;
    logic         r_b_miss;
    logic [W-2:0] r_b_lo;
    t_axis_sb     r_b_sb [NA];

    always_ff @(posedge i_clk) begin
        if (w_adv.en) begin
            r_b_miss <= w_miss;
            r_b_lo   <= w_lo[W-2:0];
            r_b_sb   <= r_a_sb;
        end
    end

    // ---------------- Stages C and D: hit point per axis
    logic signed [W-1:0] w_coord [NA];

    for (genvar a = 0; a < NA; a++) begin : g_hp
        rbsi_hitpt #(.W(W), .F(F)) u_hitpt (
            .i_clk    (i_clk),
            .i_adv    (w_adv),
            .i_origin (r_b_sb[a].org),
            .i_dmag   (r_b_sb[a].dmag),
            .i_dneg   (r_b_sb[a].dneg),
            .i_dist   (r_b_lo),
            .o_coord  (w_coord[a])
        );
    end

    logic         r_c_v;
    logic         r_c_miss;
    logic [W-2:0] r_c_lo;
    logic         r_d_v;
    logic         r_d_miss;
    logic [W-2:0] r_d_lo;

    always_ff @(posedge i_clk) begin
        if (w_adv.en) begin
            r_c_miss <= r_b_miss;
            r_c_lo   <= r_b_lo;
            r_d_miss <= r_c_miss;
            r_d_lo   <= r_c_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
        end else if (w_adv.en) begin
            r_a_v <= r_sb_v[DL-1];
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
        end
    end

    // ---------------- Output skid register
    logic                w_l_hit;
    logic [W-2:0]        w_l_dist;
    logic signed [W-1:0] w_l_crd [NA];
    logic                r_k_hit;
    logic [W-2:0]        r_k_dist;
    logic signed [W-1:0] r_k_crd [NA];

    assign w_l_hit  = !r_d_miss;
    assign w_l_dist = r_d_miss ? '0 : r_d_lo;
    for (genvar a = 0; a < NA; a++) begin : g_out
        assign w_l_crd[a] = r_d_miss ? '0 : w_coord[a];
    end

    // The skid register only fills when the last stage holds a result that is
    // not taken; the pipeline then freezes until it drains.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_v <= 1'b0;
        end else if (!r_k_v) begin
            r_k_v <= r_d_v && !o_res.ready;
        end else if (o_res.ready) begin
            r_k_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_k_v) begin
            r_k_hit  <= w_l_hit;
            r_k_dist <= w_l_dist;
            r_k_crd  <= w_l_crd;
        end
    end

    assign o_res.valid      = r_k_v || r_d_v;
    assign o_res.hit        = r_k_v ? r_k_hit : w_l_hit;
    assign o_res.entry_dist = r_k_v ? r_k_dist : w_l_dist;
    assign o_res.hit_x      = r_k_v ? r_k_crd[0] : w_l_crd[0];
    assign o_res.hit_y      = r_k_v ? r_k_crd[1] : w_l_crd[1];
    assign o_res.hit_z      = r_k_v ? r_k_crd[2] : w_l_crd[2];

    // ---------------- Checks
    `RBSI_ASSERT_IMP(a_miss_zero, i_clk, i_rst_n, o_res.valid && !o_res.hit, o_res.entry_dist == '0 && o_res.hit_x == '0 && o_res.hit_y == '0 && o_res.hit_z == '0)
    `RBSI_ASSERT_NXT(a_skid_hold, i_clk, i_rst_n, r_k_v && !o_res.ready, r_k_v)
    `RBSI_ASSERT_NXT(a_s1_moves, i_clk, i_rst_n, r_s1_v && !r_k_v, r_sb_v[0])
endmodule
